// File: rtl/exact_pattern_matcher_defines.svh
// ----------------------------------------------------------------------------
// Exact pattern matcher assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef EXACT_PATTERN_MATCHER_DEFINES_SVH
`define EXACT_PATTERN_MATCHER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define EPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define EPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/epm_pkg.sv
// ----------------------------------------------------------------------------
// epm_pkg
// Types and constants shared by the exact pattern matcher modules.
// ----------------------------------------------------------------------------
package epm_pkg;

  localparam int EPM_MAX_PATTERN_BYTES = 32;
  localparam int PATTERN_STORE         = 32;   // bytes held by the pattern registers
  localparam int PAT_WORDS             = 4;    // 64-bit pattern registers
  localparam int CFG_ADDR_W            = 6;
  localparam int CFG_DATA_W            = 64;
  localparam int LEN_W                 = 6;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  // register index, taken from paddr[5:3]
  localparam logic [2:0] REG_PAT_LOW      = 3'd0;
  localparam logic [2:0] REG_PAT_MID_LOW  = 3'd1;
  localparam logic [2:0] REG_PAT_MID_HIGH = 3'd2;
  localparam logic [2:0] REG_PAT_HIGH     = 3'd3;
  localparam logic [2:0] REG_PAT_LEN      = 3'd4;

  localparam logic [LEN_W-1:0] LEN_RESET = 6'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_of_text;
  } epm_in_t;

  typedef struct packed {
    logic        match_here;
    logic [31:0] match_start;
    logic [31:0] match_count;
  } epm_out_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [PATTERN_STORE-1:0][7:0] pattern;
    logic [LEN_W-1:0]              length;
  } epm_cfg_t;

  // per-cycle control broadcast along the cell chain
  typedef struct packed {
    logic       advance;
    logic       clear;
    logic [7:0] text_byte;
  } epm_step_t;

endpackage

// File: rtl/epm_cfg.sv
// ----------------------------------------------------------------------------
// epm_cfg
// APB register file: four 64-bit pattern words and the pattern length.
// ----------------------------------------------------------------------------
module epm_cfg
  import epm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output epm_cfg_t              cfg
);

  logic [PAT_WORDS-1:0][63:0] pat_r;
  logic [LEN_W-1:0]           len_r;
  logic [2:0]                 reg_idx;
  logic                       wr_en;

  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
      len_r <= LEN_RESET;
    end else if (wr_en) begin
      if (reg_idx inside {[REG_PAT_LOW:REG_PAT_HIGH]}) begin
        pat_r[reg_idx[1:0]] <= pwdata;
      end else if (reg_idx == REG_PAT_LEN) begin
        len_r <= pwdata[LEN_W-1:0];
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PAT_LOW:      prdata = pat_r[0];
      REG_PAT_MID_LOW:  prdata = pat_r[1];
      REG_PAT_MID_HIGH: prdata = pat_r[2];
      REG_PAT_HIGH:     prdata = pat_r[3];
      REG_PAT_LEN:      prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, len_r};
      default:          prdata = '0;
    endcase
  end

  // word 0 byte 0 lands in pattern[0]
  assign cfg.pattern = pat_r;
  assign cfg.length  = len_r;

endmodule

// File: rtl/epm_cell.sv
// ----------------------------------------------------------------------------
// epm_cell
// One bit of the shift-and partial match vector with its byte comparator.
// ----------------------------------------------------------------------------
module epm_cell
  import epm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  epm_step_t step,
  input  logic [7:0] pat_byte,
  input  logic      enable,     // cell lies inside the active pattern length
  input  logic      carry_in,   // neighbor's bit from the previous byte
  output logic      match_nxt,
  output logic      match_r
);

  assign match_nxt = carry_in && enable && (pat_byte == step.text_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (step.advance) begin
      match_r <= step.clear ? 1'b0 : match_nxt;
    end
  end

endmodule

// File: rtl/exact_pattern_matcher.sv
// ----------------------------------------------------------------------------
// exact_pattern_matcher
// Streaming exact string matcher: one text byte per transaction, reports
// every (overlapping) occurrence of a 2..32 byte pattern.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_stall   | epm_in_t  (text_byte, last_of_text)
//  out_    | output    | out_valid / out_stall | epm_out_t (match_here, start, count)
//  apb     | input     | psel/penable/pready   | 64-bit registers at 8*index
//
//  One byte per cycle while in_stall is low; each result is registered and appears
//  in the cycle after its byte is accepted. The rate is set by the combinational
//  shift-and step through the cell chain plus the 32-bit position and count adders
//  feeding the output register. Reset (synchronous, rst_n low) clears match state
//  and loads length 2. A held result stalls the input only while out_stall is high.
// ----------------------------------------------------------------------------
module exact_pattern_matcher
  import epm_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = EPM_MAX_PATTERN_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  epm_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output epm_out_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int NCELL = (MAX_PATTERN_BYTES < PATTERN_STORE) ? MAX_PATTERN_BYTES
                                                             : PATTERN_STORE;
  localparam int IDX_W = $clog2(NCELL);
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(NCELL);

  epm_cfg_t         cfg;
  epm_step_t        step;
  logic [IDX_W-1:0] last_idx;     // active length minus one
  logic [NCELL-1:0] vec_r;
  logic [NCELL-1:0] vec_nxt;
  logic [NCELL-1:0] cell_en;
  logic             accept;
  logic             hit;
  logic [31:0]      pos_r, pos_nxt;
  logic [31:0]      cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  epm_out_t         out_data_r, out_data_nxt;

  assign pready = 1'b1;

  epm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  always_comb begin
    if (cfg.length < LEN_W'(2)) begin
      last_idx = IDX_W'(1);
    end else if (cfg.length > LEN_CAP) begin
      last_idx = IDX_W'(NCELL - 1);
    end else begin
      last_idx = IDX_W'(cfg.length - LEN_W'(1));
    end
  end

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign step.advance   = accept;
  assign step.clear     = in_data.last_of_text;
  assign step.text_byte = in_data.text_byte;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    assign cell_en[k] = (IDX_W'(k) <= last_idx);

    epm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (step),
      .pat_byte  (cfg.pattern[k]),
      .enable    (cell_en[k]),
      .carry_in  ((k == 0) ? 1'b1 : vec_r[(k == 0) ? 0 : k-1]),
      .match_nxt (vec_nxt[k]),
      .match_r   (vec_r[k])
    );
  end

  assign hit = vec_nxt[last_idx];

  always_comb begin
    cnt_nxt = (hit && (cnt_r != SAT32)) ? cnt_r + 32'd1 : cnt_r;
    pos_nxt = (pos_r != SAT32) ? pos_r + 32'd1 : pos_r;

    out_data_nxt.match_here  = hit;
    out_data_nxt.match_start = hit ? pos_r - 32'(last_idx) : 32'd0;
    out_data_nxt.match_count = cnt_nxt;

    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        pos_r <= in_data.last_of_text ? 32'd0 : pos_nxt;
        cnt_r <= in_data.last_of_text ? 32'd0 : cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/epm_checker.sv
// ----------------------------------------------------------------------------
// epm_checker
// Port-level checks for the exact pattern matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "exact_pattern_matcher_defines.svh"

module epm_checker
  import epm_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input epm_out_t out_data
);

  `EPM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
  `EPM_ASSERT_NEXT(a_in_to_out, clk, rst_n, in_valid && !in_stall, out_valid, "accepted byte produced no result")
  `EPM_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled with output free")
  `EPM_ASSERT_NOW(a_nomatch_start, clk, rst_n, out_valid && !out_data.match_here, out_data.match_start == 32'd0, "start set without match")
  `EPM_ASSERT_NOW(a_match_count, clk, rst_n, out_valid && out_data.match_here, out_data.match_count != 32'd0, "match with zero count")

endmodule

bind exact_pattern_matcher epm_checker u_epm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: verif/exact_pattern_matcher_tb.sv
// ----------------------------------------------------------------------------
// exact_pattern_matcher_tb
// Self-checking bench for the streaming exact pattern matcher. Text bytes go
// in one transaction at a time. A shift-and predictor works out the expected
// match flag, start position and count, and each output transaction is
// compared with the oldest prediction. Directed texts cover length clamping,
// the end-of-text clear and mid-text reconfiguration. Random texts with
// planted and corrupted occurrences run under three idle/stall regimes.
// ----------------------------------------------------------------------------
module exact_pattern_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import epm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] PAT_REG [PAT_WORDS] =
    '{REG_PAT_LOW, REG_PAT_MID_LOW, REG_PAT_MID_HIGH, REG_PAT_HIGH};

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  epm_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  epm_out_t              out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  exact_pattern_matcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // predictor copy of configuration and match state
  logic [63:0]      pat_word [PAT_WORDS];
  logic [LEN_W-1:0] pat_len;
  logic [31:0]      partial_vec;
  logic [31:0]      text_pos;
  logic [31:0]      occ_count;

  epm_out_t    expected_results [$];
  logic [7:0]  planted_bytes [$];
  logic [7:0]  text_alpha [2];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic int unsigned eff_len();
    int unsigned cap;
    int unsigned m;
    cap = PATTERN_STORE;
    if (EPM_MAX_PATTERN_BYTES < cap) cap = EPM_MAX_PATTERN_BYTES;
    if (cap < 2) cap = 2;
    m = pat_len;
    if (m < 2) m = 2;
    if (m > cap) m = cap;
    return m;
  endfunction

  function automatic logic [7:0] pat_byte(input int unsigned k);
    return pat_word[k >> 3][(k % 8) * 8 +: 8];
  endfunction

  function automatic void clear_match_state();
    partial_vec = '0;
    text_pos    = '0;
    occ_count   = '0;
  endfunction

  // one shift-and step; updates the predictor state
  function automatic epm_out_t predict_match(input epm_in_t item);
    int unsigned m;
    int unsigned k;
    logic [31:0] mask;
    epm_out_t    res;
    m    = eff_len();
    mask = '0;
    for (k = 0; k < m; k++)
      if (pat_byte(k) == item.text_byte) mask[k] = 1'b1;
    partial_vec = ((partial_vec << 1) | 32'd1) & mask;
    res.match_here  = partial_vec[m-1];
    res.match_start = '0;
    if (res.match_here) begin
      res.match_start = text_pos - (m - 1);
      if (occ_count != SAT32) occ_count++;
    end
    if (text_pos != SAT32) text_pos++;
    res.match_count = occ_count;
    if (item.last_of_text) clear_match_state();
    return res;
  endfunction

  // output monitor: sample before the edge, check at the edge
  logic     out_take = 1'b0;
  epm_out_t out_seen;

  always @(negedge clk) begin
    out_take = rst_n && out_valid && !out_stall;
    out_seen = out_data;
  end

  always @(posedge clk) begin
    epm_out_t want;
    if (out_take) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", out_seen.match_count, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_seen.match_here !== want.match_here)
          report_mismatch("match_here", out_seen.match_here, want.match_here);
        if (out_seen.match_start !== want.match_start)
          report_mismatch("match_start", out_seen.match_start, want.match_start);
        if (out_seen.match_count !== want.match_count)
          report_mismatch("match_count", out_seen.match_count, want.match_count);
      end
    end
  end

  task automatic send_text_byte(input logic [7:0] value, input logic last);
    logic    stalled;
    epm_in_t item;
    item.text_byte    = value;
    item.last_of_text = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(negedge clk);
      stalled = in_stall;
      if (!stalled) expected_results.push_back(predict_match(item));
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // setup + access phases, then the bus returns to idle
  task automatic apb_access(input logic wr, input logic [2:0] idx,
                            input logic [63:0] wdata, output logic [63:0] rdata);
    logic ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      rdata = prdata;
      @(posedge clk);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [2:0] idx, input logic [63:0] want);
    logic [63:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (idx == REG_PAT_LEN) begin
      if (rd[LEN_W-1:0] !== want[LEN_W-1:0])
        report_mismatch("pattern_length readback", rd[LEN_W-1:0], want[LEN_W-1:0]);
    end else if (rd !== want) begin
      report_mismatch("pattern register readback", rd, want);
    end
  endtask

  // caller guarantees nothing is in flight
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    logic [63:0] rd;
    apb_access(1'b1, idx, value, rd);
    if (idx == REG_PAT_LEN) pat_len = value[LEN_W-1:0];
    else pat_word[idx[1:0]] = value;
    check_reg(idx, value);
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic load_random_config(input int len_pick);
    int          mode;
    int          w;
    int          k;
    int          len;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [63:0] word;
    wait_results_done();
    mode = $urandom_range(2);
    a0   = pick_letter();
    a1   = pick_letter();
    if (mode == 2) a1 = a0 ^ 8'h01;
    for (w = 0; w < PAT_WORDS; w++) begin
      word = {$urandom, $urandom};
      if (mode != 0)
        for (k = 0; k < 8; k++)
          word[k*8 +: 8] = (mode == 1 && $urandom_range(1)) ? a1 : a0;
      write_reg(PAT_REG[w], word);
    end
    if (mode == 0) begin
      a0 = pat_word[0][7:0];
      a1 = pat_word[0][15:8];
    end
    text_alpha[0] = a0;
    text_alpha[1] = a1;
    if (len_pick >= 0) begin
      len = len_pick;
    end else begin
      case ($urandom_range(7))
        0:       len = $urandom_range(1, 0);
        1:       len = 32;
        2:       len = $urandom_range(63, 33);
        3:       len = $urandom_range(31, 9);
        default: len = $urandom_range(8, 2);
      endcase
    end
    write_reg(REG_PAT_LEN, 64'(len));
    planted_bytes.delete();
  endtask

  // mostly planted occurrences and alphabet text, some noise and broken copies
  function automatic logic [7:0] next_text_byte();
    int unsigned m;
    int unsigned k;
    int          roll;
    if (planted_bytes.size() == 0) begin
      roll = $urandom_range(99);
      if (roll < 25) begin
        m = eff_len();
        for (k = 0; k < m; k++) planted_bytes.push_back(pat_byte(k));
        if ($urandom_range(4) == 0) begin
          k = $urandom_range(m - 1);
          planted_bytes[k] = planted_bytes[k] ^ (8'h01 << $urandom_range(7));
        end
      end else if (roll < 75) begin
        return text_alpha[$urandom_range(1)];
      end else begin
        return 8'($urandom);
      end
    end
    return planted_bytes.pop_front();
  endfunction

  task automatic test_reset_state();
    int w;
    for (w = 0; w < PAT_WORDS; w++) check_reg(PAT_REG[w], '0);
    check_reg(REG_PAT_LEN, 64'(LEN_RESET));
    // zero pattern of length 2: overlapping hits on a run of zeros
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'h00, 1'b1);
  endtask

  task automatic test_length_clamping();
    wait_results_done();
    write_reg(REG_PAT_LOW, 64'h0000_0000_0000_ABCD);
    write_reg(REG_PAT_LEN, 64'd0);
    send_text_byte(8'hCD, 1'b0);
    send_text_byte(8'hAB, 1'b0);
    send_text_byte(8'hCD, 1'b0);
    send_text_byte(8'hAB, 1'b1);
    wait_results_done();
    write_reg(REG_PAT_LEN, 64'd1);
    send_text_byte(8'hCD, 1'b0);
    send_text_byte(8'hAB, 1'b1);
    wait_results_done();
    write_reg(REG_PAT_LOW, '1);
    write_reg(REG_PAT_MID_LOW, '1);
    write_reg(REG_PAT_MID_HIGH, '1);
    write_reg(REG_PAT_HIGH, '1);
    write_reg(REG_PAT_LEN, 64'd63);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(8'hFF, 1'b1);
  endtask

  task automatic test_last_byte_clear();
    wait_results_done();
    write_reg(REG_PAT_LOW, 64'h0000_0000_0000_AAAA);
    write_reg(REG_PAT_LEN, 64'd2);
    // no occurrence may span the text boundary
    send_text_byte(8'hAA, 1'b1);
    send_text_byte(8'hAA, 1'b0);
    send_text_byte(8'hAA, 1'b1);
  endtask

  task automatic test_midtext_reconfig();
    wait_results_done();
    write_reg(REG_PAT_LOW, 64'h0000_0000_0003_0201);
    write_reg(REG_PAT_LEN, 64'd3);
    send_text_byte(8'h01, 1'b0);
    send_text_byte(8'h02, 1'b0);
    wait_results_done();
    // partial match vector survives the rewrite
    write_reg(REG_PAT_LOW, 64'h0000_0000_0004_0201);
    send_text_byte(8'h04, 1'b0);
    send_text_byte(8'h02, 1'b1);
  endtask

  task automatic test_random_traffic(input int item_goal, input int s_pct,
                                     input int r_pct, input int first_len);
    int sent;
    int chunk;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    load_random_config(first_len);
    while (sent < item_goal) begin
      chunk = $urandom_range(60, 20);
      repeat (chunk) send_text_byte(next_text_byte(), $urandom_range(49) == 0);
      sent += chunk;
      load_random_config(-1);
    end
  endtask

  initial begin
    for (int w = 0; w < PAT_WORDS; w++) pat_word[w] = '0;
    pat_len = LEN_RESET;
    clear_match_state();
    text_alpha[0] = 8'h00;
    text_alpha[1] = 8'h01;
    send_idle_pct = 20;
    recv_idle_pct = 45;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_length_clamping();
    test_last_byte_clear();
    test_midtext_reconfig();
    test_random_traffic(245, 20, 45, 32);
    test_random_traffic(245, 45, 20, 63);
    test_random_traffic(245, 0, 0, 0);

    wait_results_done();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), 0);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
